// ===== rtl/core/bldc_six_step_gate_driver_core_macros.svh =====
`ifndef BLDC_SIX_STEP_GATE_DRIVER_CORE_MACROS_SVH
`define BLDC_SIX_STEP_GATE_DRIVER_CORE_MACROS_SVH

// Same-cycle implication on clk, off while rst is high.
`define BLDC6S_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst is high.
`define BLDC6S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bldc6s_pkg.sv =====
`timescale 1ns / 1ps

package bldc6s_pkg;

  localparam int REQ_W         = 3;
  localparam int SECTOR_W      = 3;
  localparam int DIR_W         = 2;
  localparam int DUTY_W        = 16;
  localparam int MASK_W        = 3;
  localparam int CMP_W         = 13;
  localparam int DUTY_NOW_W    = 10;
  localparam int PHASE_W       = 2;
  localparam int NIB_W         = 4;
  localparam int TABLE_W       = 48;
  localparam int TABLE_ENTRIES = 12;
  localparam int NUM_SECTORS   = 6;
  localparam int IDX_W         = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam int unsigned MAX_DUTY     = 1000;
  localparam int unsigned PERIOD_TICKS = 4799;

  // duty * PERIOD_TICKS / MAX_DUTY through a reciprocal with one correction step
  localparam int PROD_W      = 2 * DUTY_W;
  localparam int QUOT_W      = DUTY_W;
  localparam int RECIP_SHIFT = PROD_W;
  localparam int RECIP_W     = PROD_W + 1;
  localparam int WIDE_W      = PROD_W + RECIP_W;
  localparam int REM_W       = DUTY_W + 1;

  localparam logic [DUTY_W-1:0]  MAX_DUTY_V     = DUTY_W'(MAX_DUTY);
  localparam logic [DUTY_W-1:0]  PERIOD_TICKS_V = DUTY_W'(PERIOD_TICKS);
  localparam logic [RECIP_W-1:0] RECIP          =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(MAX_DUTY));

  localparam logic [TABLE_W-1:0] TABLE_RESET = 48'h621984984621;

  localparam logic [REQ_W-1:0] REQ_STEP  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_OFF   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FAULT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BRAKE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOCK  = 3'd4;

  localparam logic [SECTOR_W-1:0] LAST_SECTOR = 3'd5;
  localparam logic [DIR_W-1:0]    DIR_STOP    = 2'b00;
  localparam logic [DIR_W-1:0]    DIR_FWD     = 2'b01;

  localparam logic [PHASE_W-1:0] PHASE_A    = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_B    = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_C    = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_NONE = 2'd3;

  localparam logic [MASK_W-1:0] MASK_NONE = 3'b000;
  localparam logic [MASK_W-1:0] MASK_ALL  = 3'b111;

  typedef struct packed {
    logic [REQ_W-1:0]      req;
    logic                  refuse;
    logic [PHASE_W-1:0]    high_ph;
    logic [PHASE_W-1:0]    low_ph;
    logic                  lock_value;
    logic [DUTY_NOW_W-1:0] duty_now;
    logic [CMP_W-1:0]      compare;
  } cmd_t;

  function automatic logic [NIB_W-1:0] table_entry(input logic [TABLE_W-1:0] tbl,
                                                    input logic [IDX_W-1:0] idx);
    logic [NIB_W-1:0] nib;
    nib = '1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (idx == IDX_W'(i)) begin
        nib = tbl[i*NIB_W +: NIB_W];
      end
    end
    return nib;
  endfunction

  function automatic logic [MASK_W-1:0] phase_bit(input logic [PHASE_W-1:0] p);
    logic [MASK_W-1:0] m;
    unique case (p)
      PHASE_A: m = 3'b001;
      PHASE_B: m = 3'b010;
      PHASE_C: m = 3'b100;
      default: m = MASK_NONE;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/bldc6s_front.sv =====
`timescale 1ns / 1ps

module bldc6s_front import bldc6s_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [TABLE_W-1:0]         cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [REQ_W-1:0]           req_type,
  input  logic [SECTOR_W-1:0]        sector,
  input  logic signed [DIR_W-1:0]    direction,
  input  logic [DUTY_W-1:0]          duty,
  input  logic                       lock_value,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output cmd_t                       cmd
);

  logic [TABLE_W-1:0] drive_table;

  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  cmd_t c_in, c1, c2, c3;

  logic [DUTY_W-1:0]  sat;
  logic [IDX_W-1:0]   idx;
  logic [NIB_W-1:0]   nib;
  logic [PROD_W-1:0]  p_in, p1, p2;
  logic [WIDE_W-1:0]  wide;
  logic [QUOT_W-1:0]  q2, q3, q_fix;
  logic [PROD_W-1:0]  prod, rem;
  logic [REM_W-1:0]   r3;

  assign ready3   = !v3 || cmd_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // classify and look up
  always_comb begin
    sat = (duty > MAX_DUTY_V) ? MAX_DUTY_V : duty;
    idx = (direction == DIR_FWD) ? IDX_W'(sector) : IDX_W'(sector) + IDX_W'(NUM_SECTORS);
    nib = table_entry(drive_table, idx);
    c_in.req        = req_type;
    c_in.refuse     = (sector > LAST_SECTOR) || (direction == DIR_STOP) || (duty == '0);
    c_in.high_ph    = nib[PHASE_W-1:0];
    c_in.low_ph     = nib[NIB_W-1:PHASE_W];
    c_in.lock_value = lock_value;
    c_in.duty_now   = sat[DUTY_NOW_W-1:0];
    c_in.compare    = '0;
    p_in            = PROD_W'(sat) * PROD_W'(PERIOD_TICKS_V);
  end

  assign wide  = WIDE_W'(p1) * WIDE_W'(RECIP);
  assign prod  = PROD_W'(q2) * PROD_W'(MAX_DUTY_V);
  assign rem   = p2 - prod;
  assign q_fix = q3 + QUOT_W'(r3 >= REM_W'(MAX_DUTY_V));

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_table <= TABLE_RESET;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        drive_table <= cfg_write_data;
      end
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      c1 <= c_in;
      p1 <= p_in;
    end
    if (ready2) begin
      c2 <= c1;
      p2 <= p1;
      q2 <= wide[RECIP_SHIFT +: QUOT_W];
    end
    if (ready3) begin
      c3 <= c2;
      q3 <= q2;
      r3 <= rem[REM_W-1:0];
    end
  end

  always_comb begin
    cmd         = c3;
    cmd.compare = q_fix[CMP_W-1:0];
  end

  assign cmd_valid = v3;

endmodule

// ===== rtl/core/bldc6s_queue.sv =====
`timescale 1ns / 1ps

module bldc6s_queue import bldc6s_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/bldc6s_back.sv =====
`timescale 1ns / 1ps
`include "bldc_six_step_gate_driver_core_macros.svh"

module bldc6s_back import bldc6s_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MASK_W-1:0]     high_pwm_mask,
  output logic [MASK_W-1:0]     low_on_mask,
  output logic [CMP_W-1:0]      compare_ticks,
  output logic [DUTY_NOW_W-1:0] duty_now,
  output logic                  main_output_enable,
  output logic                  lock_state,
  output logic                  commutated
);

  logic [PHASE_W-1:0]    last_high, last_low;
  logic [PHASE_W-1:0]    last_high_next, last_low_next;
  logic [MASK_W-1:0]     high_pwm_mask_next, low_on_mask_next;
  logic [CMP_W-1:0]      compare_ticks_next;
  logic [DUTY_NOW_W-1:0] duty_now_next;
  logic                  main_output_enable_next, lock_state_next, commutated_next;
  logic                  gates_off;
  logic                  pop;

  assign cmd_ready = !out_valid || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    high_pwm_mask_next      = high_pwm_mask;
    low_on_mask_next        = low_on_mask;
    compare_ticks_next      = compare_ticks;
    duty_now_next           = duty_now;
    last_high_next          = last_high;
    last_low_next           = last_low;
    main_output_enable_next = main_output_enable;
    lock_state_next         = lock_state;
    commutated_next         = 1'b0;
    gates_off               = 1'b0;

    unique case (cmd.req)
      REQ_STEP: begin
        if (cmd.refuse || lock_state) begin
          gates_off = 1'b1;
        end else begin
          main_output_enable_next = 1'b1;
          duty_now_next           = cmd.duty_now;
          compare_ticks_next      = cmd.compare;
          if ((cmd.high_ph != last_high) || (cmd.low_ph != last_low)) begin
            high_pwm_mask_next = phase_bit(cmd.high_ph);
            low_on_mask_next   = phase_bit(cmd.low_ph);
            last_high_next     = cmd.high_ph;
            last_low_next      = cmd.low_ph;
            commutated_next    = 1'b1;
          end
        end
      end
      REQ_OFF: begin
        gates_off = 1'b1;
      end
      REQ_FAULT: begin
        gates_off               = 1'b1;
        main_output_enable_next = 1'b0;
        lock_state_next         = 1'b1;
      end
      REQ_BRAKE: begin
        gates_off = 1'b1;
      end
      REQ_LOCK: begin
        lock_state_next = cmd.lock_value;
      end
      default: begin
      end
    endcase

    if (gates_off) begin
      high_pwm_mask_next = MASK_NONE;
      low_on_mask_next   = MASK_NONE;
      compare_ticks_next = '0;
      duty_now_next      = '0;
      last_high_next     = PHASE_NONE;
      last_low_next      = PHASE_NONE;
    end

    // unless locked, brake overrides the low sides once everything is off and sets the output enable
    if ((cmd.req == REQ_BRAKE) && !lock_state) begin
      low_on_mask_next        = MASK_ALL;
      main_output_enable_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      high_pwm_mask      <= MASK_NONE;
      low_on_mask        <= MASK_NONE;
      compare_ticks      <= '0;
      duty_now           <= '0;
      last_high          <= PHASE_NONE;
      last_low           <= PHASE_NONE;
      main_output_enable <= 1'b1;
      lock_state         <= 1'b0;
      commutated         <= 1'b0;
    end else begin
      if (cmd_ready) begin
        out_valid <= cmd_valid;
      end
      if (pop) begin
        high_pwm_mask      <= high_pwm_mask_next;
        low_on_mask        <= low_on_mask_next;
        compare_ticks      <= compare_ticks_next;
        duty_now           <= duty_now_next;
        last_high          <= last_high_next;
        last_low           <= last_low_next;
        main_output_enable <= main_output_enable_next;
        lock_state         <= lock_state_next;
        commutated         <= commutated_next;
      end
    end
  end

  `BLDC6S_ASSERT_SAME(a_high_single, out_valid, $onehot0(high_pwm_mask), "two high sides on")
  `BLDC6S_ASSERT_SAME(a_disabled_off, !main_output_enable, (high_pwm_mask == MASK_NONE) && (low_on_mask == MASK_NONE), "gates on while disabled")
  `BLDC6S_ASSERT_NEXT(a_commutate_step, pop && (cmd.req != REQ_STEP), !commutated, "commutation without step")
  `BLDC6S_ASSERT_NEXT(a_fault_locks, pop && (cmd.req == REQ_FAULT), lock_state && !main_output_enable, "fault did not lock")

endmodule

// ===== rtl/core/bldc_six_step_gate_driver_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// in        in_valid / in_ready         req_type, sector, direction, duty, lock_value
// out       out_valid / out_ready       high_pwm_mask, low_on_mask, compare_ticks,
//                                       duty_now, main_output_enable, lock_state,
//                                       commutated
// cfg       cfg_write_en                cfg_write_data (drive table)
//
// One item per cycle sustained while out_ready holds high; an accepted input passes the
// front's compare scaling pipeline (multiply, reciprocal, correct), the queue and the back's
// output register before result valid. Reset clears all gates, duty and compare, sets the
// output enable, clears the lock. A stalled output holds the result; the 2-entry queue and
// front stages then fill before in_ready drops.

module bldc_six_step_gate_driver_core import bldc6s_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [TABLE_W-1:0]    cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [SECTOR_W-1:0]   sector,
  input  logic signed [DIR_W-1:0] direction,
  input  logic [DUTY_W-1:0]     duty,
  input  logic                  lock_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MASK_W-1:0]     high_pwm_mask,
  output logic [MASK_W-1:0]     low_on_mask,
  output logic [CMP_W-1:0]      compare_ticks,
  output logic [DUTY_NOW_W-1:0] duty_now,
  output logic                  main_output_enable,
  output logic                  lock_state,
  output logic                  commutated
);

  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  bldc6s_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .sector         (sector),
    .direction      (direction),
    .duty           (duty),
    .lock_value     (lock_value),
    .cmd_valid      (fq_valid),
    .cmd_ready      (fq_ready),
    .cmd            (fq_cmd)
  );

  bldc6s_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  bldc6s_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (qb_valid),
    .cmd_ready          (qb_ready),
    .cmd                (qb_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .high_pwm_mask      (high_pwm_mask),
    .low_on_mask        (low_on_mask),
    .compare_ticks      (compare_ticks),
    .duty_now           (duty_now),
    .main_output_enable (main_output_enable),
    .lock_state         (lock_state),
    .commutated         (commutated)
  );

endmodule
